### hdl/text_console_cell_writer_macros.svh
// assertion macros for the port-level checker
`ifndef TEXT_CONSOLE_CELL_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CELL_WRITER_MACROS_SVH

// same-cycle implication, sampled on clk, off while reset is held
`define TCCW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tccw check failed");

// next-cycle implication, sampled on clk, off while reset is held
`define TCCW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tccw check failed");

`endif

### hdl/tccw_pkg.sv
// shared constants and types of the text console cell writer
`default_nettype none
package tccw_pkg;

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int CELLS    = COLUMNS * ROWS;
  localparam int RAM_AW   = $clog2(CELLS);
  localparam int CELL_AW  = $clog2(CELLS + 1);
  localparam int COL_W    = $clog2(COLUMNS);
  localparam int ROW_W    = $clog2(ROWS + 1);
  localparam int POS_W    = 11;
  localparam int IDX_W    = 11;
  localparam int CELL_W   = 16;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0700;
  localparam logic [7:0]        ATTR_RESET = 8'h07;
  localparam logic [7:0]        CODE_CR    = 8'd13;
  localparam logic [7:0]        CODE_LF    = 8'd10;
  localparam logic              OP_PUT     = 1'b0;
  localparam logic              OP_READ    = 1'b1;

  // cursor status towards the sequencer
  typedef struct packed {
    logic [CELL_AW-1:0] pos;
    logic               printable;
    logic               scroll;
  } tccw_cur_t;

  // screen memory port request
  typedef struct packed {
    logic              we;
    logic [RAM_AW-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic [RAM_AW-1:0] raddr;
  } tccw_ram_req_t;

  // finished item towards the result register
  typedef struct packed {
    logic       valid;
    logic       scrolled;
    logic [7:0] chr;
    logic [7:0] attr;
  } tccw_done_t;

endpackage
`default_nettype wire

### hdl/tccw_ram.sv
// generic single-write, single-read memory with registered read data
`default_nettype none
module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hdl/tccw_cursor.sv
// cursor column, row and row base tracking
`default_nettype none
module tccw_cursor (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                put_en,
  input  wire logic [7:0]          ch,
  output tccw_pkg::tccw_cur_t      cur
);
  import tccw_pkg::*;

  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [CELL_AW-1:0] base_r, base_nxt;
  logic               adv_row;
  logic               printable;
  logic               scroll;

  assign printable = (ch != CODE_CR) && (ch != CODE_LF);

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    base_nxt = base_r;
    adv_row  = 1'b0;
    scroll   = 1'b0;
    if (put_en) begin
      if (ch == CODE_CR) begin
        col_nxt = '0;
      end else if (ch == CODE_LF) begin
        adv_row = 1'b1;
      end else if (col_r == COL_W'(COLUMNS - 1)) begin
        col_nxt = '0;
        adv_row = 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
      // past the last row the cursor row stays put and the screen moves instead
      if (adv_row) begin
        if (row_r == ROW_W'(ROWS - 1)) begin
          scroll = 1'b1;
        end else begin
          row_nxt  = row_r + 1'b1;
          base_nxt = base_r + CELL_AW'(COLUMNS);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      base_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      base_r <= base_nxt;
    end
  end

  assign cur = '{pos: base_r + CELL_AW'(col_r), printable: printable, scroll: scroll};

endmodule
`default_nettype wire

### hdl/tccw_seq.sv
// sequencer: clear sweep, cell writes, reads and the scroll copy over the screen memory
`default_nettype none
module tccw_seq (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        accept,
  input  wire logic                        op,
  input  wire logic [7:0]                  ch,
  input  wire logic [tccw_pkg::IDX_W-1:0]  idx,
  input  wire logic [7:0]                  attr,
  input  tccw_pkg::tccw_cur_t              cur,
  input  wire logic [tccw_pkg::CELL_W-1:0] rdata,
  output logic                             busy,
  output tccw_pkg::tccw_ram_req_t          req,
  output tccw_pkg::tccw_done_t             done
);
  import tccw_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_PUT   = 6'b001000,
    S_COPY  = 6'b010000,
    S_FILL  = 6'b100000
  } state_t;

  localparam logic [CELL_AW-1:0] LAST_CELL = CELL_AW'(CELLS - 1);
  localparam logic [CELL_AW-1:0] LAST_ROW0 = CELL_AW'(CELLS - COLUMNS);
  localparam logic [CELL_AW-1:0] COLS_A    = CELL_AW'(COLUMNS);

  state_t             state_r, state_nxt;
  logic [CELL_AW-1:0] sweep_r, sweep_nxt;
  logic               pipe_v_r, pipe_v_nxt;
  logic [CELL_AW-1:0] pipe_addr_r, pipe_addr_nxt;
  logic               rd_ok_r, rd_ok_nxt;

  always_comb begin
    state_nxt     = state_r;
    sweep_nxt     = sweep_r;
    pipe_v_nxt    = pipe_v_r;
    pipe_addr_nxt = pipe_addr_r;
    rd_ok_nxt     = rd_ok_r;
    req.we        = 1'b0;
    req.waddr     = RAM_AW'(sweep_r);
    req.wdata     = BLANK_CELL;
    req.raddr     = RAM_AW'(idx);
    done          = '0;
    unique case (state_r)
      S_CLEAR: begin
        req.we = 1'b1;
        if (sweep_r == LAST_CELL) begin
          state_nxt = S_IDLE;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (op == OP_READ) begin
            rd_ok_nxt = ({1'b0, idx} < (IDX_W + 1)'(CELLS));
            state_nxt = S_READ;
          end else begin
            req.we    = cur.printable;
            req.waddr = RAM_AW'(cur.pos);
            req.wdata = {attr, ch};
            if (cur.scroll) begin
              sweep_nxt  = COLS_A;
              pipe_v_nxt = 1'b0;
              state_nxt  = S_COPY;
            end else begin
              state_nxt = S_PUT;
            end
          end
        end
      end
      S_READ: begin
        done.valid = 1'b1;
        if (rd_ok_r) begin
          done.chr  = rdata[7:0];
          done.attr = rdata[15:8];
        end
        state_nxt = S_IDLE;
      end
      S_PUT: begin
        done.valid = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_COPY: begin
        // read one row down, write back the word read in the previous cycle
        req.raddr     = RAM_AW'(sweep_r);
        pipe_v_nxt    = 1'b1;
        pipe_addr_nxt = sweep_r - COLS_A;
        if (pipe_v_r) begin
          req.we    = 1'b1;
          req.waddr = RAM_AW'(pipe_addr_r);
          req.wdata = rdata;
        end
        if (sweep_r == LAST_CELL) begin
          sweep_nxt = LAST_ROW0;
          state_nxt = S_FILL;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end
      S_FILL: begin
        req.we = 1'b1;
        if (pipe_v_r) begin
          // last copied word goes out first
          req.waddr  = RAM_AW'(pipe_addr_r);
          req.wdata  = rdata;
          pipe_v_nxt = 1'b0;
        end else if (sweep_r == LAST_CELL) begin
          done.valid    = 1'b1;
          done.scrolled = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      sweep_r  <= '0;
      pipe_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      sweep_r  <= sweep_nxt;
      pipe_v_r <= pipe_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pipe_addr_r <= pipe_addr_nxt;
    rd_ok_r     <= rd_ok_nxt;
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

### hdl/text_console_cell_writer.sv
// top level of the text console cell writer
//
//  channel  ports                                         handshake
//  ------   --------------------------------------------  -----------------------
//  input    in_operation, in_character, in_cell_index      start high, busy low
//  result   out_cursor_position, out_cell_character,       out_valid, one cycle
//           out_cell_attribute, out_scrolled
//  config   cfg_data                                       cfg_valid and cfg_ready
//
//  a read or a non-scrolling put goes through S_READ or S_PUT, with out_valid
//  registered from that state; a put that scrolls runs through the accepting cycle,
//  copying cells up a row, writing the last copied cell and blanking the bottom row
//  after reset busy stays high while the screen is blanked one cell at a time;
//  configuration words are taken throughout
//  results cannot be held off: each is shown for one cycle only
`default_nettype none
module text_console_cell_writer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_operation,
  input  wire logic [7:0]                  in_character,
  input  wire logic [tccw_pkg::IDX_W-1:0]  in_cell_index,
  output logic                             out_valid,
  output logic      [tccw_pkg::POS_W-1:0]  out_cursor_position,
  output logic      [7:0]                  out_cell_character,
  output logic      [7:0]                  out_cell_attribute,
  output logic                             out_scrolled,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [7:0]                  cfg_data
);
  import tccw_pkg::*;

  logic               accept;
  tccw_cur_t          cur;
  tccw_ram_req_t      req;
  tccw_done_t         done;
  logic [CELL_W-1:0]  rdata;
  logic [7:0]         attr_r;
  logic               out_valid_r;
  logic [POS_W-1:0]   pos_r;
  logic [7:0]         chr_r;
  logic [7:0]         cattr_r;
  logic               scrolled_r;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  tccw_cursor u_cursor (
    .clk    (clk),
    .rst_n  (rst_n),
    .put_en (accept && (in_operation == OP_PUT)),
    .ch     (in_character),
    .cur    (cur)
  );

  tccw_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .op     (in_operation),
    .ch     (in_character),
    .idx    (in_cell_index),
    .attr   (attr_r),
    .cur    (cur),
    .rdata  (rdata),
    .busy   (busy),
    .req    (req),
    .done   (done)
  );

  tccw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (req.we),
    .waddr (req.waddr),
    .wdata (req.wdata),
    .raddr (req.raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r      <= ATTR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        attr_r <= cfg_data;
      end
      out_valid_r <= done.valid;
    end
  end

  // cursor registers already hold the post-item position when done fires
  always_ff @(posedge clk) begin
    if (done.valid) begin
      pos_r      <= POS_W'(cur.pos);
      chr_r      <= done.chr;
      cattr_r    <= done.attr;
      scrolled_r <= done.scrolled;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cursor_position = pos_r;
  assign out_cell_character  = chr_r;
  assign out_cell_attribute  = cattr_r;
  assign out_scrolled        = scrolled_r;

endmodule
`default_nettype wire

### hdl/tccw_chk.sv
// port-level checker for the text console cell writer, bound to the top level
`default_nettype none
`include "text_console_cell_writer_macros.svh"
module tccw_chk (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        in_operation,
  input wire logic [7:0]                  in_character,
  input wire logic [tccw_pkg::IDX_W-1:0]  in_cell_index,
  input wire logic                        out_valid,
  input wire logic [tccw_pkg::POS_W-1:0]  out_cursor_position,
  input wire logic [7:0]                  out_cell_character,
  input wire logic [7:0]                  out_cell_attribute,
  input wire logic                        out_scrolled,
  input wire logic                        cfg_valid,
  input wire logic                        cfg_ready,
  input wire logic [7:0]                  cfg_data
);
  import tccw_pkg::*;

  localparam logic [POS_W-1:0] CELLS_P   = POS_W'(CELLS);
  localparam logic [POS_W-1:0] LAST_ROW0 = POS_W'(CELLS - COLUMNS);

  `TCCW_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy)
  `TCCW_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)
  `TCCW_ASSERT_NOW(a_pos_on_screen, out_valid, out_cursor_position < CELLS_P)
  `TCCW_ASSERT_NOW(a_scroll_bottom_row, out_valid && out_scrolled, out_cursor_position >= LAST_ROW0)
  `TCCW_ASSERT_NOW(a_scroll_no_cell, out_valid && out_scrolled, (out_cell_character == 8'd0) && (out_cell_attribute == 8'd0))

endmodule

bind text_console_cell_writer tccw_chk u_chk (.*);
`default_nettype wire

### tb/sv/tb_text_console_cell_writer.sv
// self-checking testbench of the text console cell writer: random bursts of words against a screen model
`default_nettype none
module tb_text_console_cell_writer;
  import tccw_pkg::*;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int DRAIN_LIMIT = 10_000;
  localparam int PHASES      = 7;
  localparam int WORDS_PER_PHASE = 67;

  typedef struct packed {
    logic             op;
    logic [7:0]       chr;
    logic [IDX_W-1:0] idx;
  } console_word_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [7:0]       chr;
    logic [7:0]       attr;
    logic             scrolled;
  } console_report_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_operation = OP_PUT;
  logic [7:0]           in_character = 8'd0;
  logic [IDX_W-1:0]     in_cell_index = '0;
  logic                 out_valid;
  logic [POS_W-1:0]     out_cursor_position;
  logic [7:0]           out_cell_character;
  logic [7:0]           out_cell_attribute;
  logic                 out_scrolled;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [7:0]           cfg_data = 8'd0;

  // screen model
  logic [CELL_W-1:0]    screen_model [0:CELLS-1];
  int                   col_model;
  int                   row_model;
  logic [7:0]           attr_model;

  console_word_t        pending_words [$];
  console_report_t      due_reports [$];
  console_word_t        word_on_bus;
  logic                 word_live = 1'b0;
  int                   burst_left = 0;
  int                   gap_left = 0;

  int                   cycle_count = 0;
  int                   fail_count = 0;
  int                   puts_taken = 0;
  int                   reads_taken = 0;
  int                   reads_off_screen = 0;
  int                   scrolls_seen = 0;
  int                   reports_seen = 0;
  int                   attr_writes = 0;

  text_console_cell_writer u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_character        (in_character),
    .in_cell_index       (in_cell_index),
    .out_valid           (out_valid),
    .out_cursor_position (out_cursor_position),
    .out_cell_character  (out_cell_character),
    .out_cell_attribute  (out_cell_attribute),
    .out_scrolled        (out_scrolled),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) cycle_count++;

  // prints or reads one word on the model and returns the report it should give
  function automatic console_report_t apply_word(console_word_t w);
    console_report_t r;
    int              pos;
    int              i;
    r = '0;
    if (w.op == OP_READ) begin
      reads_taken++;
      if (w.idx < CELLS) begin
        r.chr  = screen_model[w.idx][7:0];
        r.attr = screen_model[w.idx][15:8];
      end else begin
        reads_off_screen++;
      end
    end else begin
      puts_taken++;
      if (w.chr == CODE_CR) begin
        col_model = 0;
      end else if (w.chr == CODE_LF) begin
        row_model++;
      end else begin
        pos = row_model * COLUMNS + col_model;
        if (pos < CELLS) screen_model[pos] = {attr_model, w.chr};
        col_model++;
        if (col_model >= COLUMNS) begin
          col_model = 0;
          row_model++;
        end
      end
      if (row_model >= ROWS) begin
        for (i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
        for (i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = BLANK_CELL;
        row_model  = ROWS - 1;
        r.scrolled = 1'b1;
        scrolls_seen++;
      end
    end
    r.pos = POS_W'(row_model * COLUMNS + col_model);
    return r;
  endfunction

  function automatic logic [7:0] random_glyph();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CODE_CR || c == CODE_LF);
    return c;
  endfunction

  function automatic logic [IDX_W-1:0] random_cell_index();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return IDX_W'($urandom_range(CELLS - 2 * COLUMNS, CELLS - 1));
      8:          return IDX_W'($urandom_range(CELLS, 2 ** IDX_W - 1));
      default:    return IDX_W'($urandom_range(0, CELLS - 1));
    endcase
  endfunction

  task automatic push_word(input logic op, input logic [7:0] chr, input logic [IDX_W-1:0] idx);
    console_word_t w;
    w.op  = op;
    w.chr = chr;
    w.idx = idx;
    pending_words.push_back(w);
  endtask

  // waits until every queued word is taken and its report has come back, with a bound on the wait for reports
  task automatic wait_until_quiet();
    int waited;
    waited = 0;
    while (pending_words.size() != 0 || word_live) @(posedge clk);
    while (due_reports.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // driver: bursts of words with random gaps in between
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        due_reports.push_back(apply_word(word_on_bus));
        word_live = 1'b0;
      end
      if (!word_live) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_words.size() != 0) begin
          word_on_bus = pending_words.pop_front();
          word_live   = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      start         <= word_live;
      in_operation  <= word_on_bus.op;
      in_character  <= word_on_bus.chr;
      in_cell_index <= word_on_bus.idx;
    end
  end

  // monitor: each strobed report against the oldest prediction
  always @(posedge clk) begin
    console_report_t want;
    if (rst_n && out_valid) begin
      if (due_reports.size() == 0) begin
        $error("report with nothing outstanding: cursor_position %0d", out_cursor_position);
        fail_count++;
      end else begin
        want = due_reports.pop_front();
        reports_seen++;
        if (out_cursor_position !== want.pos) begin
          $error("cursor_position expected %0d actual %0d", want.pos, out_cursor_position);
          fail_count++;
        end
        if (out_cell_character !== want.chr) begin
          $error("cell_character expected %0h actual %0h", want.chr, out_cell_character);
          fail_count++;
        end
        if (out_cell_attribute !== want.attr) begin
          $error("cell_attribute expected %0h actual %0h", want.attr, out_cell_attribute);
          fail_count++;
        end
        if (out_scrolled !== want.scrolled) begin
          $error("scrolled expected %0b actual %0b", want.scrolled, out_scrolled);
          fail_count++;
        end
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $error("run timed out after %0d cycles", cycle_count);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int         phase;
    int         queued;
    int         n;
    int         k;
    logic [7:0] attr;
    for (int i = 0; i < CELLS; i++) screen_model[i] = BLANK_CELL;
    col_model  = 0;
    row_model  = 0;
    attr_model = ATTR_RESET;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: screen corners, off-screen reads, zero and top bytes, cr and lf
    push_word(OP_READ, 8'h00, 11'd0);
    push_word(OP_READ, 8'hff, 11'd1999);
    push_word(OP_READ, 8'h00, 11'd2000);
    push_word(OP_READ, 8'hff, 11'h7ff);
    push_word(OP_PUT,  8'h00, 11'h7ff);
    push_word(OP_PUT,  8'hff, 11'd0);
    push_word(OP_PUT,  CODE_CR, 11'h555);
    push_word(OP_READ, 8'h5a, 11'd0);
    push_word(OP_READ, 8'ha5, 11'd1);
    push_word(OP_PUT,  CODE_LF, 11'h2aa);
    push_word(OP_PUT,  8'h41, 11'd0);
    push_word(OP_PUT,  8'h7f, 11'h7ff);
    push_word(OP_READ, 8'h00, 11'd80);
    push_word(OP_READ, 8'h00, 11'd81);
    push_word(OP_PUT,  CODE_LF, 11'd0);
    push_word(OP_PUT,  CODE_CR, 11'd0);
    push_word(OP_PUT,  8'h55, 11'd0);
    push_word(OP_PUT,  8'haa, 11'd0);
    push_word(OP_READ, 8'h00, 11'd160);
    push_word(OP_READ, 8'h00, 11'd161);

    for (phase = 1; phase < PHASES; phase++) begin
      wait_until_quiet();
      case (phase)
        1:       attr = 8'h00;
        2:       attr = 8'hff;
        4:       attr = 8'h07;
        default: attr = 8'($urandom_range(0, 255));
      endcase
      @(posedge clk);
      cfg_valid <= 1'b1;
      cfg_data  <= attr;
      do @(posedge clk); while (!cfg_ready);
      cfg_valid <= 1'b0;
      attr_model = attr;
      attr_writes++;

      // mostly text lines closed by cr/lf, with reads, blank lines and noise mixed in
      queued = 0;
      while (queued < WORDS_PER_PHASE) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 10);
            for (k = 0; k < n; k++) push_word(OP_PUT, random_glyph(), 11'($urandom_range(0, 2047)));
            case ($urandom_range(0, 3))
              0, 1: begin
                push_word(OP_PUT, CODE_CR, 11'($urandom_range(0, 2047)));
                push_word(OP_PUT, CODE_LF, 11'($urandom_range(0, 2047)));
              end
              2: begin
                push_word(OP_PUT, CODE_LF, 11'($urandom_range(0, 2047)));
                push_word(OP_PUT, CODE_CR, 11'($urandom_range(0, 2047)));
              end
              default: push_word(OP_PUT, CODE_LF, 11'($urandom_range(0, 2047)));
            endcase
            queued += n + 2;
          end
          6, 7: begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++) push_word(OP_READ, 8'($urandom_range(0, 255)), random_cell_index());
            queued += n;
          end
          8: begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++) push_word(OP_PUT, CODE_LF, 11'($urandom_range(0, 2047)));
            queued += n;
          end
          default: begin
            push_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      11'($urandom_range(0, 2047)));
            queued++;
          end
        endcase
      end
    end

    wait_until_quiet();
    repeat (10) @(posedge clk);
    if (due_reports.size() != 0) begin
      $error("%0d reports never arrived", due_reports.size());
      fail_count++;
    end

    $display("run covered %0d puts and %0d reads (%0d past the screen end), %0d scrolls",
             puts_taken, reads_taken, reads_off_screen, scrolls_seen);
    $display("%0d reports checked over %0d attribute settings, %0d mismatches",
             reports_seen, attr_writes + 1, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
